[hdl/ipd_pkg.sv]
// shared types, constants and helpers of the ir pulse distance decoder
`default_nettype none

package ipd_pkg;

  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned FRAME_BITS = 24;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [WIDTH_W-1:0] HEADER_MIN_RST = 16'd3500;
  localparam logic [WIDTH_W-1:0] HEADER_MAX_RST = 16'd5000;
  localparam logic [WIDTH_W-1:0] ZERO_MIN_RST   = 16'd850;
  localparam logic [WIDTH_W-1:0] ZERO_MAX_RST   = 16'd1100;
  localparam logic [WIDTH_W-1:0] ONE_MIN_RST    = 16'd1200;
  localparam logic [WIDTH_W-1:0] ONE_MAX_RST    = 16'd2300;

  localparam logic [COUNT_W-1:0] LAST_BIT = COUNT_W'(FRAME_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_MIN = 3'd0,
    CFG_HEADER_MAX = 3'd1,
    CFG_ZERO_MIN   = 3'd2,
    CFG_ZERO_MAX   = 3'd3,
    CFG_ONE_MIN    = 3'd4,
    CFG_ONE_MAX    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_HDR_HIGH = 2'd1,
    PH_BIT_LOW  = 2'd2,
    PH_BIT_HIGH = 2'd3
  } phase_e;

  typedef enum logic {
    ST_DECODED = 1'b0,
    ST_ABORTED = 1'b1
  } status_e;

  typedef struct packed {
    logic [WIDTH_W-1:0] header_min;
    logic [WIDTH_W-1:0] header_max;
    logic [WIDTH_W-1:0] zero_min;
    logic [WIDTH_W-1:0] zero_max;
    logic [WIDTH_W-1:0] one_min;
    logic [WIDTH_W-1:0] one_max;
  } cfg_t;

  typedef struct packed {
    logic       frame_status;
    logic [7:0] user_code;
    logic [3:0] user_data;
    logic [3:0] key_code;
    logic [7:0] key_data;
  } result_t;

  // exclusive window test
  function automatic logic in_window(logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] lo,
                                     logic [WIDTH_W-1:0] hi);
    return (w > lo) && (w < hi);
  endfunction

endpackage

`default_nettype wire

[hdl/ir_pulse_distance_decoder_top.sv]
// top level of the ir pulse distance decoder
// Usage:
//   s_axis carries one measured pulse per request: tdata[0] is the line
//   level, tdata[16:1] the width in microseconds. m_axis carries one frame
//   result per decoded or aborted frame: tuser is the status (0 decoded,
//   1 aborted), tdata holds user code, user data, key code and key data.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write the six window bounds; write them
//   only while no pulse is in flight.
// Timing:
//   a pulse is taken into an input register, decoded combinationally
//   against the frame state and its result, if any, lands in the output
//   register, which drives m_axis.
//   one pulse per cycle is sustained while m_axis does not stall; the
//   frame state machine steps once per pulse as it leaves the input register.
// Reset:
//   all windows return to their defaults, the decoder waits for a header
//   and both register stages are empty.
// Stall:
//   while a result waits on m_axis the input register still holds one
//   pulse; s_axis_tready_o drops only when both stages are occupied.
`default_nettype none

module ir_pulse_distance_decoder_top
  import ipd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [0] pulse_level, [16:1] pulse_width_us, [23:17] zero
  input  wire logic [23:0]          s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [7:0] user_code, [11:8] user_data, [15:12] key_code, [23:16] key_data
  output logic [23:0]               m_axis_tdata_o,
  // [0] frame_status
  output logic                      m_axis_tuser_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [WIDTH_W-1:0]   cfg_wdata_i
);

  cfg_t               cfg;
  logic               in_vld_q;
  logic               level_q;
  logic [WIDTH_W-1:0] width_q;
  logic               out_vld_q;
  result_t            out_q;
  logic               advance;
  logic               res_vld;
  result_t            res;

  ipd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ipd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .level_i   (level_q),
    .width_i   (width_q),
    .cfg_i     (cfg),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // the held pulse moves on once the output register is free or draining
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      level_q <= s_axis_tdata_i[0];
      width_q <= s_axis_tdata_i[WIDTH_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.frame_status;
  assign m_axis_tdata_o  = {out_q.key_data, out_q.key_code, out_q.user_data, out_q.user_code};

endmodule

`default_nettype wire

[hdl/ipd_cfg_regs.sv]
// configuration register file of the ir pulse distance decoder
`default_nettype none

module ipd_cfg_regs
  import ipd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [WIDTH_W-1:0]   cfg_wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_HEADER_MIN: cfg_d.header_min = cfg_wdata_i;
        CFG_HEADER_MAX: cfg_d.header_max = cfg_wdata_i;
        CFG_ZERO_MIN:   cfg_d.zero_min   = cfg_wdata_i;
        CFG_ZERO_MAX:   cfg_d.zero_max   = cfg_wdata_i;
        CFG_ONE_MIN:    cfg_d.one_min    = cfg_wdata_i;
        CFG_ONE_MAX:    cfg_d.one_max    = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_min <= HEADER_MIN_RST;
      cfg_q.header_max <= HEADER_MAX_RST;
      cfg_q.zero_min   <= ZERO_MIN_RST;
      cfg_q.zero_max   <= ZERO_MAX_RST;
      cfg_q.one_min    <= ONE_MIN_RST;
      cfg_q.one_max    <= ONE_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/ipd_decode.sv]
// frame state machine: header check, bit decode and result forming
`default_nettype none

module ipd_decode
  import ipd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire logic               level_i,
  input  wire logic [WIDTH_W-1:0] width_i,
  input  wire cfg_t               cfg_i,
  output logic                    res_vld_o,
  output result_t                 res_o
);

  phase_e                phase_q, phase_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;

  logic                  hdr_ok, zero_ok, one_ok;
  logic [FRAME_BITS-1:0] shift_in;

  assign hdr_ok   = in_window(width_i, cfg_i.header_min, cfg_i.header_max);
  assign zero_ok  = in_window(width_i, cfg_i.zero_min, cfg_i.zero_max);
  assign one_ok   = in_window(width_i, cfg_i.one_min, cfg_i.one_max);
  // zero window wins when the windows overlap
  assign shift_in = {!zero_ok, shift_q[FRAME_BITS-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      shift_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      shift_q <= shift_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    shift_d   = shift_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (!level_i && hdr_ok) phase_d = PH_HDR_HIGH;
      end
      PH_HDR_HIGH: begin
        phase_d = (level_i && hdr_ok) ? PH_BIT_LOW : PH_IDLE;
        count_d = '0;
        shift_d = '0;
      end
      PH_BIT_LOW: begin
        if (level_i) begin
          res_vld_o          = 1'b1;
          res_o.frame_status = ST_ABORTED;
          phase_d            = PH_IDLE;
          count_d            = '0;
          shift_d            = '0;
        end else begin
          phase_d = PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        if (!level_i || !(zero_ok || one_ok)) begin
          res_vld_o          = 1'b1;
          res_o.frame_status = ST_ABORTED;
          phase_d            = PH_IDLE;
          count_d            = '0;
          shift_d            = '0;
        end else if (count_q == LAST_BIT) begin
          res_vld_o          = 1'b1;
          res_o.frame_status = ST_DECODED;
          res_o.user_code    = shift_in[7:0];
          res_o.user_data    = shift_in[15:12];
          res_o.key_code     = shift_in[11:8];
          res_o.key_data     = shift_in[23:16];
          phase_d            = PH_IDLE;
          count_d            = '0;
          shift_d            = '0;
        end else begin
          phase_d = PH_BIT_LOW;
          count_d = count_q + COUNT_W'(1);
          shift_d = shift_in;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

endmodule

`default_nettype wire
